### rtl/hydrodynamic_wrench_unit_macros.svh
// ----------------------------------------------------------------------------
// Hydrodynamic wrench unit assertion macros
// Shared concurrent assertion forms for the wrench pipeline.
// ----------------------------------------------------------------------------
`ifndef HYDRODYNAMIC_WRENCH_UNIT_MACROS_SVH
`define HYDRODYNAMIC_WRENCH_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define HWR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define HWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hwr_pkg.sv
// ----------------------------------------------------------------------------
// Hydrodynamic wrench package
// Widths, register codes, reset values and shared types of the wrench unit.
// ----------------------------------------------------------------------------
package hwr_pkg;

    // Component and register geometry
    localparam int unsigned CW    = 16;           // Q8.8 / Q1.14 component
    localparam int unsigned NAX   = 3;            // axes per triple
    localparam int unsigned NLANE = 2 * NAX;      // force lanes
    localparam int unsigned CFGW  = NAX * CW;     // one config register
    localparam int unsigned IDXW  = 3;            // config index width
    localparam int unsigned QUATW = 4 * CW;       // orientation word
    localparam int unsigned OW    = 32;           // Q16.16 result

    // Lane datapath widths
    localparam int unsigned QPW = 2 * CW;         // 16x16 product
    localparam int unsigned DW  = 33;             // lin*256 + quad*|v|
    localparam int unsigned AMW = 33;             // added * a
    localparam int unsigned FW  = 49;             // body force, Q24.24

    // Rotation datapath widths
    localparam int unsigned MW  = 34;             // matrix element, Q2.28
    localparam int unsigned FLW = 24;             // low slice of a force
    localparam int unsigned FHW = FW - FLW;       // high slice of a force
    localparam int unsigned PW  = MW + FHW;       // partial product
    localparam int unsigned SW  = PW + 2;         // sum of three partials

    // Register indexes
    localparam logic [IDXW-1:0] REG_ADDED_LIN = 3'd0;
    localparam logic [IDXW-1:0] REG_ADDED_ANG = 3'd1;
    localparam logic [IDXW-1:0] REG_LDRAG_LIN = 3'd2;
    localparam logic [IDXW-1:0] REG_LDRAG_ANG = 3'd3;
    localparam logic [IDXW-1:0] REG_QDRAG_LIN = 3'd4;
    localparam logic [IDXW-1:0] REG_QDRAG_ANG = 3'd5;

    // Register reset values
    localparam logic [CFGW-1:0] RST_ADDED_LIN = 48'h001A_0500_0500;
    localparam logic [CFGW-1:0] RST_ADDED_ANG = 48'h0100_001A_001A;
    localparam logic [CFGW-1:0] RST_LDRAG_LIN = 48'h1400_1400_1400;
    localparam logic [CFGW-1:0] RST_LDRAG_ANG = 48'h1400_1400_1400;
    localparam logic [CFGW-1:0] RST_QDRAG_LIN = 48'h0000_0000_0000;
    localparam logic [CFGW-1:0] RST_QDRAG_ANG = 48'h0000_0000_0000;

    // Load enables of the front stages (lanes and quaternion matrix)
    typedef struct packed {
        logic ld0;
        logic ld1;
        logic ld2;
    } t_front_en;

    // Load enables of the merging stages (rotation rows)
    typedef struct packed {
        logic ld3;
        logic ld4;
        logic ld5;
    } t_back_en;

    // Rotation matrix, row major, element 0 lowest
    typedef logic [3*NAX-1:0][MW-1:0] t_mat;

endpackage

### rtl/hwr_lane.sv
// ----------------------------------------------------------------------------
// Hydrodynamic wrench force lane
// Three-stage body-frame force of one axis: -(lin + quad*|v|)*v - added*a.
// ----------------------------------------------------------------------------
module hwr_lane (
    input  logic                    i_clk,
    input  hwr_pkg::t_front_en      i_en,
    input  logic [hwr_pkg::CW-1:0]  i_lin,
    input  logic [hwr_pkg::CW-1:0]  i_quad,
    input  logic [hwr_pkg::CW-1:0]  i_added,
    input  logic [hwr_pkg::CW-1:0]  i_vel,
    input  logic [hwr_pkg::CW-1:0]  i_acc,
    output logic [hwr_pkg::FW-1:0]  o_force
);
    import hwr_pkg::*;

    logic [CW-1:0]           w_abs;
    logic [QPW-1:0]          r_qav;
    logic signed [AMW-1:0]   r_am0;
    logic [CW-1:0]           r_lin0;
    logic signed [CW-1:0]    r_v0;
    logic [DW-1:0]           r_d;
    logic signed [AMW-1:0]   r_am1;
    logic signed [CW-1:0]    r_v1;
    logic signed [DW+CW:0]   w_dv;
    logic signed [DW+CW:0]   w_fw;
    logic [FW-1:0]           r_f;

    // Magnitude of the velocity; the most negative code maps to 0x8000
    assign w_abs = i_vel[CW-1] ? (~i_vel + CW'(1)) : i_vel;

    // Stage 0: quadratic drag term and added-mass term
    always_ff @(posedge i_clk) begin
        if (i_en.ld0) begin
            r_qav  <= i_quad * w_abs;
            r_am0  <= $signed({1'b0, i_added}) * $signed(i_acc);
            r_lin0 <= i_lin;
            r_v0   <= $signed(i_vel);
        end
    end

    // Stage 1: total damping coefficient in Q16.16
    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r_d   <= DW'({r_lin0, 8'h00}) + DW'(r_qav);
            r_am1 <= r_am0;
            r_v1  <= r_v0;
        end
    end

    // Stage 2: damping times velocity, minus added-mass force, in Q24.24
    assign w_dv = $signed({1'b0, r_d}) * r_v1;
    assign w_fw = -w_dv - ((DW + CW + 1)'(r_am1) <<< 8);

    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r_f <= w_fw[FW-1:0];
        end
    end

    assign o_force = r_f;

endmodule

### rtl/hwr_quat.sv
// ----------------------------------------------------------------------------
// Hydrodynamic wrench rotation matrix
// Builds the unnormalized rotation matrix of a Q1.14 quaternion in Q2.28.
// ----------------------------------------------------------------------------
module hwr_quat (
    input  logic                       i_clk,
    input  hwr_pkg::t_front_en         i_en,
    input  logic [hwr_pkg::QUATW-1:0]  i_orient,
    output hwr_pkg::t_mat              o_mat
);
    import hwr_pkg::*;

    logic signed [CW-1:0]  w_w, w_x, w_y, w_z;
    logic signed [QPW-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    t_mat                  r_m1;
    t_mat                  r_m2;

    // Quaternion components, w lowest
    assign w_w = $signed(i_orient[CW-1:0]);
    assign w_x = $signed(i_orient[2*CW-1:CW]);
    assign w_y = $signed(i_orient[3*CW-1:2*CW]);
    assign w_z = $signed(i_orient[4*CW-1:3*CW]);

    // Stage 0: pairwise products
    always_ff @(posedge i_clk) begin
        if (i_en.ld0) begin
            r_ww <= w_w * w_w;
            r_xx <= w_x * w_x;
            r_yy <= w_y * w_y;
            r_zz <= w_z * w_z;
            r_xy <= w_x * w_y;
            r_wz <= w_w * w_z;
            r_xz <= w_x * w_z;
            r_wy <= w_w * w_y;
            r_yz <= w_y * w_z;
            r_wx <= w_w * w_x;
        end
    end

    // Stage 1: combine into the nine matrix elements
    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r_m1[0] <= MW'(r_ww) + MW'(r_xx) - MW'(r_yy) - MW'(r_zz);
            r_m1[1] <= (MW'(r_xy) - MW'(r_wz)) <<< 1;
            r_m1[2] <= (MW'(r_xz) + MW'(r_wy)) <<< 1;
            r_m1[3] <= (MW'(r_xy) + MW'(r_wz)) <<< 1;
            r_m1[4] <= MW'(r_ww) - MW'(r_xx) + MW'(r_yy) - MW'(r_zz);
            r_m1[5] <= (MW'(r_yz) - MW'(r_wx)) <<< 1;
            r_m1[6] <= (MW'(r_xz) - MW'(r_wy)) <<< 1;
            r_m1[7] <= (MW'(r_yz) + MW'(r_wx)) <<< 1;
            r_m1[8] <= MW'(r_ww) - MW'(r_xx) - MW'(r_yy) + MW'(r_zz);
        end
    end

    // Stage 2: align with the lane forces
    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r_m2 <= r_m1;
        end
    end

    assign o_mat = r_m2;

endmodule

### rtl/hwr_rot.sv
// ----------------------------------------------------------------------------
// Hydrodynamic wrench rotation row
// Dot product of one matrix row with a force triple, rounded and saturated to Q16.16.
// ----------------------------------------------------------------------------
module hwr_rot (
    input  logic                                  i_clk,
    input  hwr_pkg::t_back_en                     i_en,
    input  logic [hwr_pkg::NAX-1:0][hwr_pkg::MW-1:0] i_m,
    input  logic [hwr_pkg::NAX-1:0][hwr_pkg::FW-1:0] i_f,
    output logic [hwr_pkg::OW-1:0]                o_val
);
    import hwr_pkg::*;

    localparam int unsigned RNDSH = 12;           // Q33.28 merged sum down to Q16.16
    localparam int unsigned QW    = SW + 1;
    localparam int unsigned RW    = QW - RNDSH;

    logic signed [PW-1:0] r_pl [NAX];
    logic signed [PW-1:0] r_ph [NAX];
    logic signed [SW-1:0] r_sl;
    logic signed [SW-1:0] r_sh;
    logic signed [QW-1:0] w_q;
    logic signed [RW-1:0] w_r;
    logic [RW-OW:0]       w_top;
    logic                 w_ovf;
    logic [OW-1:0]        w_sat;
    logic [OW-1:0]        r_out;

    // Stage 3: split each force into low and high slices and multiply
    always_ff @(posedge i_clk) begin
        if (i_en.ld3) begin
            for (int k = 0; k < NAX; k++) begin
                r_pl[k] <= $signed(i_m[k]) * $signed({1'b0, i_f[k][FLW-1:0]});
                r_ph[k] <= $signed(i_m[k]) * $signed(i_f[k][FW-1:FLW]);
            end
        end
    end

    // Stage 4: accumulate the partials of each slice
    always_ff @(posedge i_clk) begin
        if (i_en.ld4) begin
            r_sl <= SW'(r_pl[0]) + SW'(r_pl[1]) + SW'(r_pl[2]);
            r_sh <= SW'(r_ph[0]) + SW'(r_ph[1]) + SW'(r_ph[2]);
        end
    end

    // Stage 5: merge slices, round half up, saturate
    assign w_q   = QW'(r_sh) + QW'(r_sl >>> FLW) + QW'(1 << (RNDSH - 1));
    assign w_r   = RW'(w_q >>> RNDSH);
    assign w_top = w_r[RW-1:OW-1];
    assign w_ovf = !((&w_top) || !(|w_top));
    assign w_sat = w_r[RW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};

    always_ff @(posedge i_clk) begin
        if (i_en.ld5) begin
            r_out <= w_ovf ? w_sat : w_r[OW-1:0];
        end
    end

    assign o_val = r_out;

endmodule

### rtl/hydrodynamic_wrench_unit.sv
// ----------------------------------------------------------------------------
// Hydrodynamic wrench unit
// Added-mass and drag wrench of a rigid body, rotated into the world frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one item per vehicle state, carrying linear and
//   angular velocity and acceleration (Q8.8) and the orientation quaternion
//   (Q1.14) in tdata, and the readings-valid flag in tuser.
//   Output stream (m_axis): one item per input item, in order, carrying the
//   world-frame force and torque (Q16.16, saturated) in tdata and the
//   wrench-valid flag in tuser. Missing readings give an all-zero wrench.
//   Configuration channel: index 0..5 selects the added-mass, linear drag
//   and quadratic drag registers; other indexes are dropped. Always ready.
//   The item passes six register stages, three lane stages (six axis lanes
//   and the quaternion matrix side by side) then three rotation stages.
//   Throughput is one item per cycle while the receiver is ready.
//   Reset clears all stage valid flags and loads the default coefficients.
//   A stalled receiver holds the output item; each stage advances into any
//   bubble ahead of it, so input is still taken until all six stages fill.
// ----------------------------------------------------------------------------
module hydrodynamic_wrench_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [47:0] linear_velocity, [95:48] angular_velocity, [143:96] linear_accel,
    // [191:144] angular_accel, [255:192] orientation
    input  logic [255:0]                  s_axis_tdata,
    // [0] readings_valid
    input  logic [0:0]                    s_axis_tuser,
    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] force_x, [63:32] force_y, [95:64] force_z,
    // [127:96] torque_x, [159:128] torque_y, [191:160] torque_z
    output logic [191:0]                  m_axis_tdata,
    // [0] wrench_valid
    output logic [0:0]                    m_axis_tuser,
    // Configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hwr_pkg::IDXW-1:0]      i_cfg_index,
    input  logic [hwr_pkg::CFGW-1:0]      i_cfg_data
);
    import hwr_pkg::*;

`include "hydrodynamic_wrench_unit_macros.svh"

    localparam int unsigned NSTG = 6;

    logic [CFGW-1:0]             r_added_lin, r_added_ang;
    logic [CFGW-1:0]             r_ldrag_lin, r_ldrag_ang;
    logic [CFGW-1:0]             r_qdrag_lin, r_qdrag_ang;
    logic [NSTG-1:0]             r_vld;
    logic [NSTG-1:0]             w_ld;
    logic [NSTG-1:0]             r_rdv;
    t_front_en                   w_fen;
    t_back_en                    w_ben;
    logic [NLANE-1:0][CW-1:0]    w_lin, w_quad, w_added, w_vel, w_acc;
    logic [NLANE-1:0][FW-1:0]    w_force;
    t_mat                        w_mat;
    logic [NLANE-1:0][OW-1:0]    w_row;
    logic                        w_in_acc;
    logic                        w_out_acc;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_added_lin <= RST_ADDED_LIN;
            r_added_ang <= RST_ADDED_ANG;
            r_ldrag_lin <= RST_LDRAG_LIN;
            r_ldrag_ang <= RST_LDRAG_ANG;
            r_qdrag_lin <= RST_QDRAG_LIN;
            r_qdrag_ang <= RST_QDRAG_ANG;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ADDED_LIN: r_added_lin <= i_cfg_data;
                REG_ADDED_ANG: r_added_ang <= i_cfg_data;
                REG_LDRAG_LIN: r_ldrag_lin <= i_cfg_data;
                REG_LDRAG_ANG: r_ldrag_ang <= i_cfg_data;
                REG_QDRAG_LIN: r_qdrag_lin <= i_cfg_data;
                REG_QDRAG_ANG: r_qdrag_ang <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage load enables: a stage advances when empty or when its successor moves
    always_comb begin
        w_ld[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    assign w_fen = '{ld0: w_ld[0], ld1: w_ld[1], ld2: w_ld[2]};
    assign w_ben = '{ld3: w_ld[3], ld4: w_ld[4], ld5: w_ld[5]};

    assign s_axis_tready = w_ld[0];
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Carry the readings flag alongside the data
    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_rdv[0] <= s_axis_tuser[0];
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_ld[k]) begin
                r_rdv[k] <= r_rdv[k-1];
            end
        end
    end

    // Lane operands: linear axes in lanes 0..2, angular axes in lanes 3..5
    assign w_lin   = {r_ldrag_ang, r_ldrag_lin};
    assign w_quad  = {r_qdrag_ang, r_qdrag_lin};
    assign w_added = {r_added_ang, r_added_lin};
    assign w_vel   = s_axis_tdata[2*CFGW-1:0];
    assign w_acc   = s_axis_tdata[4*CFGW-1:2*CFGW];

    // Axis force lanes
    for (genvar g = 0; g < NLANE; g++) begin : g_lane
        hwr_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_fen),
            .i_lin   (w_lin[g]),
            .i_quad  (w_quad[g]),
            .i_added (w_added[g]),
            .i_vel   (w_vel[g]),
            .i_acc   (w_acc[g]),
            .o_force (w_force[g])
        );
    end

    // Quaternion rotation matrix
    hwr_quat u_quat (
        .i_clk    (i_clk),
        .i_en     (w_fen),
        .i_orient (s_axis_tdata[4*CFGW+QUATW-1:4*CFGW]),
        .o_mat    (w_mat)
    );

    // Rotation rows: force rows 0..2, torque rows 3..5
    for (genvar g = 0; g < NLANE; g++) begin : g_row
        hwr_rot u_rot (
            .i_clk (i_clk),
            .i_en  (w_ben),
            .i_m   (w_mat[NAX*(g % NAX) +: NAX]),
            .i_f   (w_force[NAX*(g / NAX) +: NAX]),
            .o_val (w_row[g])
        );
    end

    // Output item: zero wrench when readings were missing
    assign m_axis_tvalid   = r_vld[NSTG-1];
    assign m_axis_tuser[0] = r_rdv[NSTG-1];
    assign m_axis_tdata    = r_rdv[NSTG-1] ? w_row : '0;

    // Assertions
    `HWR_ASSERT_NEXT(a_occupancy, i_clk, i_rst_n, 1'b1,
        $countones(r_vld) == $past($countones(r_vld)) + $past(w_in_acc) - $past(w_out_acc),
        "pipeline occupancy does not match accepted and delivered items")
    `HWR_ASSERT_NOW(a_ready_when_out_free, i_clk, i_rst_n, !m_axis_tvalid,
        s_axis_tready, "input not ready while output stage is empty")
    `HWR_ASSERT_NOW(a_accept_needs_room, i_clk, i_rst_n,
        w_in_acc && m_axis_tvalid && !m_axis_tready,
        $countones(r_vld) < NSTG, "item accepted into a full stalled pipeline")

endmodule
